/* rtl/imu_sfp_pkg.sv */
`default_nettype none

package imu_sfp_pkg;

   // frame type bytes
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   // sync byte after reset
   localparam logic [7:0] SYNC_RESET = 8'h55;

   // frame kind codes on the result
   localparam logic [1:0] KIND_ACCEL = 2'd0;

   // frame position: hunting, first data byte, checksum byte
   localparam logic [3:0] POS_HUNT = 4'd0;
   localparam logic [3:0] POS_DATA = 4'd2;
   localparam logic [3:0] POS_CSUM = 4'd10;

   localparam int PAYLOAD_DEPTH = 8;

   // checksum status codes
   localparam logic STATUS_GOOD = 1'b0;
   localparam logic STATUS_BAD  = 1'b1;

   // one decoded frame
   typedef struct packed {
      logic [1:0]         frame_kind;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic signed [15:0] value_z;
      logic signed [15:0] value_extra;
      logic               frame_status;
   } result_type;

endpackage

`default_nettype wire

/* rtl/imu_sfp_parser.sv */
`default_nettype none

module imu_sfp_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              rx_byte,
   input  wire logic                    burst_end,
   input  wire logic [7:0]              sync_byte,
   output logic                         res_valid,
   output imu_sfp_pkg::result_type      res_data
);

   logic [7:0] payload_ff [imu_sfp_pkg::PAYLOAD_DEPTH];
   logic       prev_sync_ff, prev_sync_in;
   logic [3:0] pos_ff, pos_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] sum_ff, sum_in;
   logic       halted_ff, halted_in;
   logic       pay_we;
   logic [3:0] pay_offset;
   logic [2:0] pay_idx;
   logic       is_type;
   logic       bad;

   assign is_type = (rx_byte == imu_sfp_pkg::TYPE_ACCEL) ||
                    (rx_byte == imu_sfp_pkg::TYPE_RATE)  ||
                    (rx_byte == imu_sfp_pkg::TYPE_ANGLE);
   assign bad        = (sum_ff != rx_byte);
   assign pay_offset = pos_ff - imu_sfp_pkg::POS_DATA;
   assign pay_idx    = pay_offset[2:0];

   // next state of the frame tracker for the byte at the input
   always_comb begin
      prev_sync_in = prev_sync_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      sum_in       = sum_ff;
      halted_in    = halted_ff;
      pay_we       = 1'b0;
      res_valid    = 1'b0;
      if (!halted_ff) begin
         if (pos_ff == imu_sfp_pkg::POS_HUNT) begin
            if (prev_sync_ff && is_type) begin
               kind_in      = rx_byte[1:0] - 2'd1;
               sum_in       = sync_byte + rx_byte;
               pos_in       = imu_sfp_pkg::POS_DATA;
               prev_sync_in = 1'b0;
            end else begin
               prev_sync_in = (rx_byte == sync_byte);
            end
         end else if (pos_ff < imu_sfp_pkg::POS_CSUM) begin
            pay_we = 1'b1;
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 4'd1;
         end else begin
            // checksum byte closes the frame
            res_valid    = accept;
            pos_in       = imu_sfp_pkg::POS_HUNT;
            prev_sync_in = 1'b0;
            sum_in       = 8'd0;
            if (bad) begin
               halted_in = 1'b1;
            end
         end
      end
      // idle line: hunting restarts
      if (burst_end) begin
         prev_sync_in = 1'b0;
         pos_in       = imu_sfp_pkg::POS_HUNT;
         sum_in       = 8'd0;
         halted_in    = 1'b0;
      end
   end

   // result fields from the stored data bytes
   always_comb begin
      res_data.frame_kind   = kind_ff;
      res_data.value_x      = {payload_ff[1], payload_ff[0]};
      res_data.value_y      = {payload_ff[3], payload_ff[2]};
      res_data.value_z      = {payload_ff[5], payload_ff[4]};
      res_data.value_extra  = (kind_ff == imu_sfp_pkg::KIND_ACCEL) ?
                              {payload_ff[7], payload_ff[6]} : 16'sd0;
      res_data.frame_status = bad ? imu_sfp_pkg::STATUS_BAD : imu_sfp_pkg::STATUS_GOOD;
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sync_ff <= 1'b0;
         pos_ff       <= imu_sfp_pkg::POS_HUNT;
         kind_ff      <= imu_sfp_pkg::KIND_ACCEL;
         sum_ff       <= 8'd0;
         halted_ff    <= 1'b0;
      end else if (accept) begin
         prev_sync_ff <= prev_sync_in;
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         sum_ff       <= sum_in;
         halted_ff    <= halted_in;
      end
   end

   // data byte store
   always_ff @(posedge clock) begin
      if (accept && pay_we) begin
         payload_ff[pay_idx] <= rx_byte;
      end
   end

endmodule

`default_nettype wire

/* rtl/imu_sfp_out_buf.sv */
`default_nettype none

module imu_sfp_out_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire imu_sfp_pkg::result_type in_data,
   output logic                         full,
   output logic                         out_valid,
   output imu_sfp_pkg::result_type      out_data,
   input  wire logic                    out_stall
);

   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   imu_sfp_pkg::result_type out_data_ff, out_data_in;
   imu_sfp_pkg::result_type skid_data_ff, skid_data_in;

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && out_stall) begin
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

/* rtl/imu_serial_frame_parser.sv */
// IMU serial frame parser
//
// req channel: one received byte per item (req_rx_byte) with req_burst_end
// set on the last byte before an idle line. An item is taken when req_valid
// is high and req_stall is low; one byte can be taken every cycle.
// rsp channel: one decoded frame per item, raised on the checksum byte of
// an 11-byte frame (sync, type, eight data bytes, checksum). rsp_value_*
// are raw little-endian counts, rsp_frame_status flags a checksum mismatch.
// The result is registered in the output buffer, or in its skid entry while the receiver stalls.
// Throughput: one byte per cycle while req_stall is low; the frame tracker updates on every taken byte.
// csr channel: writes the sync byte; csr_ready is always high.
// Reset: sync byte returns to 0x55, the tracker hunts for sync, the output
// buffer empties.
// Receiver stall: the current result holds; one more result fits in a skid
// entry, and req_stall rises only while that entry is occupied.
`default_nettype none

module imu_serial_frame_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_burst_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_frame_kind,
   output logic signed [15:0]      rsp_value_x,
   output logic signed [15:0]      rsp_value_y,
   output logic signed [15:0]      rsp_value_z,
   output logic signed [15:0]      rsp_value_extra,
   output logic                    rsp_frame_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_sync_byte
);

   logic                    csr_write;
   logic [7:0]              sync_byte_ff;
   logic                    accept;
   logic                    res_valid;
   logic                    buf_full;
   imu_sfp_pkg::result_type res_data;
   imu_sfp_pkg::result_type out_data;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;
   assign csr_write = csr_valid && csr_ready;

   // sync byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= imu_sfp_pkg::SYNC_RESET;
      end else if (csr_write) begin
         sync_byte_ff <= csr_sync_byte;
      end
   end

   imu_sfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .burst_end (req_burst_end),
      .sync_byte (sync_byte_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   imu_sfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_frame_kind   = out_data.frame_kind;
   assign rsp_value_x      = out_data.value_x;
   assign rsp_value_y      = out_data.value_y;
   assign rsp_value_z      = out_data.value_z;
   assign rsp_value_extra  = out_data.value_extra;
   assign rsp_frame_status = out_data.frame_status;

endmodule

`default_nettype wire

/* rtl/imu_sfp_checker.sv */
`default_nettype none

module imu_sfp_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_burst_end,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_frame_kind,
   input  wire logic signed [15:0] rsp_value_x,
   input  wire logic signed [15:0] rsp_value_y,
   input  wire logic signed [15:0] rsp_value_z,
   input  wire logic signed [15:0] rsp_value_extra,
   input  wire logic               rsp_frame_status
);

   // a stalled input item stays
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_rx_byte) && $stable(req_burst_end))
      else $error("stalled input item changed");

   // a stalled result stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_frame_kind) && $stable(rsp_value_x) &&
         $stable(rsp_value_y) && $stable(rsp_value_z) &&
         $stable(rsp_value_extra) && $stable(rsp_frame_status))
      else $error("stalled result changed");

   // a new result only follows a taken byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without a taken byte");

   // only three frame kinds exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_kind != 2'd3)
      else $error("illegal frame kind");

   // extra value is zero except for acceleration frames
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind != imu_sfp_pkg::KIND_ACCEL |-> rsp_value_extra == 16'sd0)
      else $error("extra value set on a non-acceleration frame");

endmodule

bind imu_serial_frame_parser imu_sfp_checker u_checker (.*);

`default_nettype wire

/* verif/imu_serial_frame_parser_tb.sv */
`timescale 1ns / 100ps

module imu_serial_frame_parser_tb;

   // one byte on the serial side, with its idle-line mark
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last;
   } line_byte_type;

   // frame tracker mirror and queue of decoded frames still owed by the block
   class frame_scoreboard;
      logic [7:0] sync_byte;
      logic       prev_sync;
      logic [3:0] frame_pos;
      logic [1:0] cur_kind;
      logic [7:0] sum;
      logic [7:0] payload [0:7];
      logic       halted;
      imu_sfp_pkg::result_type pending [$];
      int         errors;
      int         bytes_in;
      int         frames_checked;
      int         bad_checked;

      function new();
         sync_byte = imu_sfp_pkg::SYNC_RESET;
         cur_kind = imu_sfp_pkg::KIND_ACCEL;
         foreach (payload[i]) payload[i] = 8'h00;
         errors = 0;
         bytes_in = 0;
         frames_checked = 0;
         bad_checked = 0;
         restart();
      endfunction

      // idle line: back to hunting
      function void restart();
         prev_sync = 1'b0;
         frame_pos = imu_sfp_pkg::POS_HUNT;
         sum = 8'h00;
         halted = 1'b0;
      endfunction

      function void set_sync(logic [7:0] value);
         sync_byte = value;
      endfunction

      // track one accepted byte, queue a decoded frame on its checksum byte
      function void note_byte(logic [7:0] b, logic last);
         imu_sfp_pkg::result_type frame;
         logic       is_type;
         logic       bad;
         logic [7:0] delta;
         bytes_in++;
         if (!halted) begin
            if (frame_pos == imu_sfp_pkg::POS_HUNT) begin
               is_type = (b == imu_sfp_pkg::TYPE_ACCEL) || (b == imu_sfp_pkg::TYPE_RATE) ||
                         (b == imu_sfp_pkg::TYPE_ANGLE);
               if (prev_sync && is_type) begin
                  delta = b - imu_sfp_pkg::TYPE_ACCEL;
                  cur_kind = delta[1:0];
                  sum = sync_byte + b;
                  frame_pos = imu_sfp_pkg::POS_DATA;
                  prev_sync = 1'b0;
               end else begin
                  prev_sync = (b == sync_byte);
               end
            end else if (frame_pos < imu_sfp_pkg::POS_CSUM) begin
               delta = 8'(frame_pos - imu_sfp_pkg::POS_DATA);
               payload[delta[2:0]] = b;
               sum = sum + b;
               frame_pos = frame_pos + 4'd1;
            end else begin
               bad = (sum != b);
               frame.frame_kind = cur_kind;
               frame.value_x = {payload[1], payload[0]};
               frame.value_y = {payload[3], payload[2]};
               frame.value_z = {payload[5], payload[4]};
               frame.value_extra = (cur_kind == imu_sfp_pkg::KIND_ACCEL) ?
                                   {payload[7], payload[6]} : 16'sd0;
               frame.frame_status = bad ? imu_sfp_pkg::STATUS_BAD : imu_sfp_pkg::STATUS_GOOD;
               pending.push_back(frame);
               frame_pos = imu_sfp_pkg::POS_HUNT;
               prev_sync = 1'b0;
               sum = 8'h00;
               if (bad) halted = 1'b1;
            end
         end
         if (last) restart();
      endfunction

      task report(string what);
         if (errors < 40) $display("mismatch: %s", what);
         errors++;
      endtask

      // compare one accepted frame with the oldest one owed
      task check_frame(imu_sfp_pkg::result_type got);
         imu_sfp_pkg::result_type want;
         if (pending.size() == 0) begin
            report("frame delivered with none outstanding");
            return;
         end
         want = pending.pop_front();
         frames_checked++;
         if (want.frame_status == imu_sfp_pkg::STATUS_BAD) bad_checked++;
         if (got.frame_kind !== want.frame_kind)
            report($sformatf("frame_kind got %0d want %0d", got.frame_kind, want.frame_kind));
         if (got.value_x !== want.value_x)
            report($sformatf("value_x got %h want %h", got.value_x, want.value_x));
         if (got.value_y !== want.value_y)
            report($sformatf("value_y got %h want %h", got.value_y, want.value_y));
         if (got.value_z !== want.value_z)
            report($sformatf("value_z got %h want %h", got.value_z, want.value_z));
         if (got.value_extra !== want.value_extra)
            report($sformatf("value_extra got %h want %h", got.value_extra, want.value_extra));
         if (got.frame_status !== want.frame_status)
            report($sformatf("frame_status got %0d want %0d",
                             got.frame_status, want.frame_status));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_burst_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_frame_kind;
   logic signed [15:0] rsp_value_x;
   logic signed [15:0] rsp_value_y;
   logic signed [15:0] rsp_value_z;
   logic signed [15:0] rsp_value_extra;
   logic               rsp_frame_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_sync_byte = imu_sfp_pkg::SYNC_RESET;

   frame_scoreboard sb = new();
   line_byte_type   tx_line [$];
   logic [7:0]      cur_sync = imu_sfp_pkg::SYNC_RESET;
   bit              quiet = 1'b0;
   int              hold_left = 0;
   int              sync_settings = 1;

   imu_serial_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_burst_end    (req_burst_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_value_x      (rsp_value_x),
      .rsp_value_y      (rsp_value_y),
      .rsp_value_z      (rsp_value_z),
      .rsp_value_extra  (rsp_value_extra),
      .rsp_frame_status (rsp_frame_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sync_byte    (csr_sync_byte)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // stimulus building
   function automatic void push_byte(logic [7:0] b, logic last);
      line_byte_type it;
      it.rx_byte = b;
      it.last = last;
      tx_line.push_back(it);
   endfunction

   // sync, type, eight data bytes (value_x in data[15:0] up to extra in data[63:48]),
   // checksum; cut keeps only the first cut bytes and ends the burst there
   function automatic void push_frame(logic [7:0] type_b, logic [63:0] data,
                                      bit corrupt, int cut, bit last);
      logic [7:0] frame [0:10];
      logic [7:0] csum;
      int         n;
      frame[0] = cur_sync;
      frame[1] = type_b;
      for (int i = 0; i < 8; i++) frame[2 + i] = data[8 * i +: 8];
      csum = 8'h00;
      for (int i = 0; i < 10; i++) csum = csum + frame[i];
      if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
      frame[10] = csum;
      n = (cut > 0) ? cut : 11;
      for (int i = 0; i < n; i++) push_byte(frame[i], (i == n - 1) && (cut > 0 || last));
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(2))
         0: return imu_sfp_pkg::TYPE_ACCEL;
         1: return imu_sfp_pkg::TYPE_RATE;
         default: return imu_sfp_pkg::TYPE_ANGLE;
      endcase
   endfunction

   function automatic logic [63:0] pick_data();
      case ($urandom_range(9))
         0: return 64'h0;
         1: return '1;
         2: return {4{16'h8000}};
         3: return {4{16'h7FFF}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(3))
         0: return cur_sync;
         1: return pick_type();
         default: return 8'($urandom);
      endcase
   endfunction

   // bursts of mostly well-formed frames with bad checksums, cut frames and noise mixed in
   function automatic void build_bursts(int target);
      int parts;
      int pick;
      target = target + tx_line.size();
      while (tx_line.size() < target) begin
         parts = $urandom_range(1, 4);
         repeat (parts) begin
            pick = $urandom_range(99);
            if (pick < 68) push_frame(pick_type(), pick_data(), 1'b0, 0, 1'b0);
            else if (pick < 76) push_frame(pick_type(), pick_data(), 1'b1, 0, 1'b0);
            else if (pick < 84)
               push_frame(pick_type(), pick_data(), 1'b0, $urandom_range(1, 10), 1'b0);
            else repeat ($urandom_range(1, 4)) push_byte(pick_noise(), 1'b0);
         end
         if ($urandom_range(4) != 0) tx_line[tx_line.size() - 1].last = 1'b1;
      end
   endfunction

   // offer one item, holding it until taken
   task automatic send_item(line_byte_type it);
      bit taken;
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= it.rx_byte;
      req_burst_end <= it.last;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      sb.note_byte(it.rx_byte, it.last);
   endtask

   task automatic send_line();
      while (tx_line.size() > 0) send_item(tx_line.pop_front());
      req_valid <= 1'b0;
   endtask

   // let every owed frame arrive, then let the clock run on for bytes that made none
   task automatic wait_idle();
      int guard;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending.size() != 0) begin
         sb.report($sformatf("%0d frames never delivered", sb.pending.size()));
         sb.pending.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sync(logic [7:0] value);
      bit done;
      csr_valid <= 1'b1;
      csr_sync_byte <= value;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      sb.set_sync(value);
      cur_sync = value;
      sync_settings++;
   endtask

   // result side: random stalls, long hold-off on request, check on every taken frame
   initial begin : rsp_side
      imu_sfp_pkg::result_type got;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 14);
         end
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.frame_kind = rsp_frame_kind;
            got.value_x = rsp_value_x;
            got.value_y = rsp_value_y;
            got.value_z = rsp_value_z;
            got.value_extra = rsp_value_extra;
            got.frame_status = rsp_frame_status;
            sb.check_frame(got);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("imu_serial_frame_parser regression: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames at the reset sync byte
      push_frame(imu_sfp_pkg::TYPE_ACCEL, 64'h0, 1'b0, 0, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_RATE, {4{16'h8000}}, 1'b0, 0, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_ANGLE, {4{16'h7FFF}}, 1'b0, 0, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_ACCEL, '1, 1'b0, 0, 1'b1);
      // doubled sync, then sync followed by a plain byte
      push_byte(cur_sync, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_RATE, {$urandom, $urandom}, 1'b0, 0, 1'b0);
      push_byte(cur_sync, 1'b0);
      push_byte(8'h50, 1'b0);
      // checksum equal to sync, followed by a type byte that must not open a frame
      push_frame(imu_sfp_pkg::TYPE_ACCEL, 64'hAF, 1'b0, 0, 1'b0);
      push_byte(imu_sfp_pkg::TYPE_RATE, 1'b0);
      push_byte(8'h01, 1'b0);
      // frame cut by an idle line, then one cut just before its checksum
      push_frame(imu_sfp_pkg::TYPE_ANGLE, {$urandom, $urandom}, 1'b0, 6, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_RATE, {$urandom, $urandom}, 1'b0, 10, 1'b0);
      // bad checksum silences the rest of the burst
      push_frame(imu_sfp_pkg::TYPE_RATE, {$urandom, $urandom}, 1'b1, 0, 1'b0);
      push_frame(imu_sfp_pkg::TYPE_ACCEL, {$urandom, $urandom}, 1'b0, 0, 1'b1);
      push_frame(imu_sfp_pkg::TYPE_ANGLE, {$urandom, $urandom}, 1'b0, 0, 1'b1);
      send_line();
      wait_idle();

      write_sync(8'h00);
      build_bursts(50);
      send_line();
      wait_idle();

      // back-pressure: result side holds off while bytes keep coming
      write_sync(8'hFF);
      quiet = 1'b1;
      hold_left = 180;
      repeat (8) push_frame(pick_type(), pick_data(), 1'b0, 0, 1'b0);
      build_bursts(20);
      send_line();
      wait_idle();
      quiet = 1'b0;

      // sync byte that is also a type byte
      write_sync(imu_sfp_pkg::TYPE_ACCEL);
      build_bursts(40);
      send_line();
      wait_idle();

      write_sync(8'($urandom));
      build_bursts(40);
      send_line();
      wait_idle();

      write_sync(imu_sfp_pkg::SYNC_RESET);
      build_bursts(40);
      send_line();
      wait_idle();

      $display("covered %0d bytes, %0d frames checked (%0d with checksum mismatch)",
               sb.bytes_in, sb.frames_checked, sb.bad_checked);
      $display("over %0d sync byte settings, with random stalls and a long result hold-off",
               sync_settings);
      if (sb.errors == 0) begin
         $display("imu_serial_frame_parser regression: pass");
      end else begin
         $display("imu_serial_frame_parser regression: fail");
      end
      $finish;
   end

endmodule
